[rtl/core/mi_pkg.sv]
package mi_pkg;

  localparam int DATA_BITS_DEFAULT = 31;
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GROW,
    ST_DIV,
    ST_UPDATE,
    ST_REDUCE,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic grow;
    logic div;
    logic update;
    logic reduce;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic a_zero;
    logic grow_ok;
    logic k_zero;
    logic rem_zero;
  } status_t;

endpackage

[rtl/core/mi_in_if.sv]
interface mi_in_if #(
  parameter int DATA_BITS = mi_pkg::DATA_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/core/mi_out_if.sv]
interface mi_out_if #(
  parameter int DATA_BITS = mi_pkg::DATA_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] inverse_value;
  logic                 coprime;

  modport source (output valid, output inverse_value, output coprime, input ready);
  modport sink   (input valid, input inverse_value, input coprime, output ready);
endinterface

[rtl/core/modular_inverse.sv]
// Modular inverse by the extended Euclidean algorithm.
//
// operand (valid/ready): one beat carries a value to invert. result
// (valid/ready): one beat per operand with inverse_value, reduced into
// 0..modulus-1, and coprime, set when gcd(value, modulus) is 1.
// cfg_we/cfg_data write the modulus; write only while the block is idle.
//
// One operand is worked on at a time. Each Euclid step runs a
// shift-subtract divider: it aligns the divisor by shifting it left by k,
// peels quotient bits from position k down to zero (the product q*cv is
// built in the same pass), then rotates the remainder and coefficient
// pairs, where k is the bit length of the step's quotient minus one.
// A zero operand skips the divider. operand.ready is high only
// between items.
//
// Reset clears the state machine and the result slot and loads the
// default modulus 1000000007. When the receiver stalls, the result is held
// in its output register; the next operand is accepted meanwhile and runs
// up to its final cycle, where it waits for the slot to drain.
module modular_inverse #(
  parameter int DATA_BITS = mi_pkg::DATA_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [DATA_BITS-1:0] cfg_data,
  mi_in_if.sink                operand,
  mi_out_if.source             result
);

  localparam logic [DATA_BITS-1:0] MOD_RESET = mi_pkg::MODULUS_RESET[DATA_BITS-1:0];

  logic [DATA_BITS-1:0] modulus;
  logic                 out_valid;
  logic [DATA_BITS-1:0] out_inverse;
  logic                 out_coprime;
  logic                 out_free;

  mi_pkg::cmd_t         cmd;
  mi_pkg::status_t      status;
  logic [DATA_BITS-1:0] dp_inverse;
  logic                 dp_coprime;

  // modulus register: plain write, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // result slot may be refilled in the cycle it drains
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until the beat is taken
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_inverse <= dp_inverse;
      out_coprime <= dp_coprime;
    end
  end

  assign result.valid         = out_valid;
  assign result.inverse_value = out_inverse;
  assign result.coprime       = out_coprime;

  mi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operand.valid),
    .in_ready (operand.ready),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  mi_datapath #(
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .modulus       (modulus),
    .value         (operand.value),
    .inverse_value (dp_inverse),
    .coprime       (dp_coprime)
  );

endmodule

[rtl/core/mi_ctrl.sv]
module mi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_free,
  input  mi_pkg::status_t  status,
  output mi_pkg::cmd_t     cmd
);

  mi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mi_pkg::ST_IDLE: begin
        if (in_valid) state_next = mi_pkg::ST_CHECK;
      end
      mi_pkg::ST_CHECK: begin
        state_next = status.a_zero ? mi_pkg::ST_REDUCE : mi_pkg::ST_GROW;
      end
      mi_pkg::ST_GROW: begin
        if (!status.grow_ok) state_next = mi_pkg::ST_DIV;
      end
      mi_pkg::ST_DIV: begin
        if (status.k_zero) state_next = mi_pkg::ST_UPDATE;
      end
      mi_pkg::ST_UPDATE: begin
        state_next = status.rem_zero ? mi_pkg::ST_REDUCE : mi_pkg::ST_GROW;
      end
      mi_pkg::ST_REDUCE: begin
        state_next = mi_pkg::ST_FINISH;
      end
      mi_pkg::ST_FINISH: begin
        if (out_free) state_next = mi_pkg::ST_IDLE;
      end
      default: begin
        state_next = mi_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      mi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mi_pkg::ST_CHECK: begin
      end
      mi_pkg::ST_GROW: begin
        cmd.grow = status.grow_ok;
      end
      mi_pkg::ST_DIV: begin
        cmd.div = 1'b1;
      end
      mi_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      mi_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
      end
      mi_pkg::ST_FINISH: begin
        cmd.finish = out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/mi_datapath.sv]
module mi_datapath #(
  parameter int DATA_BITS = mi_pkg::DATA_BITS_DEFAULT
) (
  input  logic                 clk,
  input  mi_pkg::cmd_t         cmd,
  output mi_pkg::status_t      status,
  input  logic [DATA_BITS-1:0] modulus,
  input  logic [DATA_BITS-1:0] value,
  output logic [DATA_BITS-1:0] inverse_value,
  output logic                 coprime
);

  // coefficients stay within +-modulus; two spare bits cover the sign
  localparam int CW = DATA_BITS + 2;
  localparam int KW = $clog2(DATA_BITS);

  logic [DATA_BITS-1:0] m_reg;     // remainder pair, larger
  logic [DATA_BITS-1:0] a_reg;     // remainder pair, smaller
  logic [DATA_BITS:0]   d_reg;     // shifted divisor
  logic [KW-1:0]        k_reg;     // quotient bit position
  logic [CW-1:0]        prod;      // quotient times cv, built MSB first
  logic [CW-1:0]        cu;
  logic [CW-1:0]        cv;
  logic [DATA_BITS-1:0] red;       // reduced magnitude
  logic                 neg_reg;

  logic [DATA_BITS:0]   d_dbl;
  logic                 qbit;
  logic                 cu_neg;
  logic [CW-1:0]        mag;
  logic [CW-1:0]        mag_sub;
  logic                 mag_ge;
  logic                 mod_zero;

  assign d_dbl   = {d_reg[DATA_BITS-1:0], 1'b0};
  assign qbit    = {1'b0, m_reg} >= d_reg;
  assign cu_neg  = cu[CW-1];
  assign mag     = cu_neg ? (~cu + CW'(1)) : cu;
  assign mag_sub = mag - CW'(modulus);
  assign mag_ge  = mag >= CW'(modulus);

  assign status.a_zero   = (a_reg == '0);
  assign status.grow_ok  = (d_dbl <= {1'b0, m_reg});
  assign status.k_zero   = (k_reg == '0);
  assign status.rem_zero = (m_reg == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_reg <= modulus;
      a_reg <= value;
      d_reg <= {1'b0, value};
      k_reg <= '0;
      prod  <= '0;
      cu    <= '0;
      cv    <= CW'(1);
    end else if (cmd.grow) begin
      d_reg <= d_dbl;
      k_reg <= k_reg + KW'(1);
    end else if (cmd.div) begin
      if (qbit) m_reg <= m_reg - d_reg[DATA_BITS-1:0];
      prod  <= {prod[CW-2:0], 1'b0} + (qbit ? cv : '0);
      d_reg <= d_reg >> 1;
      k_reg <= k_reg - KW'(1);
    end else if (cmd.update) begin
      // m_reg holds the remainder here: rotate the pairs
      m_reg <= a_reg;
      a_reg <= m_reg;
      d_reg <= {1'b0, m_reg};
      k_reg <= '0;
      prod  <= '0;
      cu    <= cv;
      cv    <= cu - prod;
    end else if (cmd.reduce) begin
      red     <= mag_ge ? mag_sub[DATA_BITS-1:0] : mag[DATA_BITS-1:0];
      neg_reg <= cu_neg;
    end
  end

  assign mod_zero      = (modulus == '0);
  assign inverse_value = mod_zero ? '0 :
                         ((neg_reg && red != '0) ? (modulus - red) : red);
  assign coprime       = !mod_zero && (m_reg == DATA_BITS'(1));

endmodule

[rtl/core/mi_checker.sv]
module mi_checker #(
  parameter int DATA_BITS = mi_pkg::DATA_BITS_DEFAULT
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DATA_BITS-1:0] out_inverse
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // one operand at a time: no second beat right after a beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("operand accepted while busy");

  // the shortest run still passes the check, reduce and finish states before the result
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !$rose(out_valid))
    else $error("result appeared one cycle after operand");

  // the inverse is never unknown while shown
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_inverse))
    else $error("result payload unknown");

endmodule

bind modular_inverse mi_checker #(
  .DATA_BITS (DATA_BITS)
) u_mi_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (operand.valid),
  .in_ready    (operand.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_inverse (result.inverse_value)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int DB = mi_pkg::DATA_BITS_DEFAULT;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SEGMENT_ITEMS = 200;
  localparam int SEGMENTS = 7;
  localparam bit [DB-1:0] FULL = {DB{1'b1}};

  // One pending comparison: the operand, the modulus in force when it was
  // accepted, and the inverse and coprime flag the block must return.
  typedef struct {
    bit [DB-1:0] value;
    bit [DB-1:0] modulus;
    bit [DB-1:0] inverse_value;
    bit          coprime;
  } inverse_check_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [DB-1:0] cfg_data = '0;

  mi_in_if  #(.DATA_BITS(DB)) operand_if ();
  mi_out_if #(.DATA_BITS(DB)) result_if ();

  modular_inverse #(.DATA_BITS(DB)) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .operand (operand_if.sink),
    .result  (result_if.source)
  );

  // Operands waiting to be offered, and inverses waiting to come back.
  bit [DB-1:0]    pending_values[$];
  inverse_check_t expected_inverses[$];

  // Modulus the predictor works with; tracks every register write.
  bit [DB-1:0] active_modulus = mi_pkg::MODULUS_RESET[DB-1:0];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int sink_hold_left = 0;
  bit operand_taken = 1'b0;

  int error_count = 0;
  int results_checked = 0;
  int noncoprime_seen = 0;
  int modulus_writes = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  // Extended Euclid on 64-bit wrapping coefficients, then fold the final
  // coefficient into 0..modulus-1. A zero modulus has no meaning: all zeros.
  function automatic inverse_check_t predict_inverse(bit [DB-1:0] m, bit [DB-1:0] v);
    bit [63:0] rem_hi, rem_lo, coef_prev, coef_cur, q, t, mag, red;
    bit neg;
    inverse_check_t r;
    r.value = v;
    r.modulus = m;
    r.inverse_value = '0;
    r.coprime = 1'b0;
    if (m == '0) return r;
    rem_hi = 64'(m);
    rem_lo = 64'(v);
    coef_prev = 64'd0;
    coef_cur = 64'd1;
    while (rem_lo != 64'd0) begin
      q = rem_hi / rem_lo;
      t = rem_hi - q * rem_lo;
      rem_hi = rem_lo;
      rem_lo = t;
      t = coef_prev - q * coef_cur;
      coef_prev = coef_cur;
      coef_cur = t;
    end
    neg = coef_prev[63];
    mag = neg ? (64'd0 - coef_prev) : coef_prev;
    red = mag % 64'(m);
    if (neg && red != 64'd0) red = 64'(m) - red;
    r.inverse_value = red[DB-1:0];
    r.coprime = (rem_hi == 64'd1);
    return r;
  endfunction

  // Mix of operand shapes: full width (often above the modulus), in range,
  // tiny, next to the modulus, sharing a factor with it, bit patterns, zero.
  function automatic bit [DB-1:0] pick_value(bit [DB-1:0] m);
    bit [DB-1:0] v;
    int unsigned sel;
    int unsigned p;
    sel = $urandom_range(0, 99);
    p = 0;
    if (sel < 35) begin
      v = DB'($urandom());
    end else if (sel < 65) begin
      v = (m > 1) ? DB'($urandom_range(1, 32'(m) - 1)) : DB'($urandom());
    end else if (sel < 73) begin
      v = DB'($urandom_range(0, 64));
    end else if (sel < 80) begin
      v = m + DB'($urandom_range(0, 2)) - DB'(1);
    end else if (sel < 90) begin
      for (int d = 2; d < 1000 && p == 0; d++)
        if (m % DB'(d) == 0 && m != DB'(d)) p = d;
      v = (p != 0) ? DB'(p * $urandom_range(1, 32'h7FFF_FFFF / p)) : m;
    end else if (sel < 96) begin
      v = ($urandom_range(0, 1) == 1) ? FULL : (DB'(1) << $urandom_range(0, DB - 1));
    end else begin
      v = '0;
    end
    return v;
  endfunction

  // Sample both channels at the rising edge. Predict at operand acceptance,
  // check each result beat against the oldest prediction.
  always @(posedge clk) begin : sample
    inverse_check_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_inverses.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: inverse_value=%0d coprime=%0b",
                 $time, result_if.inverse_value, result_if.coprime);
        error_count++;
      end else begin
        want = expected_inverses.pop_front();
        results_checked++;
        if (!want.coprime) noncoprime_seen++;
        if (result_if.inverse_value !== want.inverse_value) begin
          $display("%0t: inverse_value mismatch (value %0d mod %0d): expected %0d, got %0d",
                   $time, want.value, want.modulus, want.inverse_value,
                   result_if.inverse_value);
          error_count++;
        end
        if (result_if.coprime !== want.coprime) begin
          $display("%0t: coprime mismatch (value %0d mod %0d): expected %0b, got %0b",
                   $time, want.value, want.modulus, want.coprime, result_if.coprime);
          error_count++;
        end
      end
    end
    if (!rst && operand_if.valid && operand_if.ready) begin
      expected_inverses.push_back(predict_inverse(active_modulus, operand_if.value));
      void'(pending_values.pop_front());
      operand_taken = 1'b1;
    end
  end

  // Operand driver: hold an offered beat until taken, otherwise offer the
  // next pending value or idle with junk on the data lines.
  always @(negedge clk) begin
    if (!operand_if.valid || operand_taken) begin
      if (!rst && pending_values.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        operand_if.valid <= 1'b1;
        operand_if.value <= pending_values[0];
      end else begin
        operand_if.valid <= 1'b0;
        operand_if.value <= DB'($urandom());
      end
    end
    operand_taken = 1'b0;
  end

  // Result receiver: random stalls, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (sink_hold_left > 0) begin
      sink_hold_left <= sink_hold_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d operands pending and %0d results outstanding",
               $time, pending_values.size(), expected_inverses.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Hold until every queued operand has been taken and answered.
  task automatic drain_all();
    while (pending_values.size() != 0 || expected_inverses.size() != 0)
      @(posedge clk);
  endtask

  // Write the modulus only with the block idle; let any tail of work settle.
  task automatic write_modulus(bit [DB-1:0] m);
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    active_modulus = m;
    modulus_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= DB'($urandom());
    @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_values.push_back(pick_value(active_modulus));
  endtask

  initial begin
    bit [DB-1:0] seg_modulus;
    operand_if.valid = 1'b0;
    operand_if.value = '0;
    result_if.ready = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset modulus, edges of the operand range, values at and
    // above the modulus, zero, alternating bit patterns.
    pending_values.push_back('0);
    pending_values.push_back(DB'(1));
    pending_values.push_back(DB'(2));
    pending_values.push_back(active_modulus - DB'(1));
    pending_values.push_back(active_modulus);
    pending_values.push_back(active_modulus + DB'(1));
    pending_values.push_back(FULL);
    pending_values.push_back(DB'(1) << (DB - 1));
    pending_values.push_back(DB'({(DB + 1) / 2{2'b10}}));
    pending_values.push_back(DB'({(DB + 1) / 2{2'b01}}));
    pending_values.push_back(DB'(500000004));
    pending_values.push_back(DB'(123456789));

    // Smallest legal modulus, including zero, an even operand with no inverse.
    write_modulus(DB'(2));
    pending_values.push_back('0);
    pending_values.push_back(DB'(1));
    pending_values.push_back(DB'(3));
    pending_values.push_back(FULL);

    // Degenerate moduli: one always inverts to zero, zero has no meaning.
    write_modulus(DB'(1));
    pending_values.push_back('0);
    pending_values.push_back(DB'(5));
    write_modulus('0);
    pending_values.push_back('0);
    pending_values.push_back(DB'(7));

    // Largest modulus.
    write_modulus(FULL);
    pending_values.push_back('0);
    pending_values.push_back(FULL);
    pending_values.push_back(FULL - DB'(1));

    // Random segments, each under its own modulus and one of three idling mixes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: seg_modulus = DB'(1000000007);
        1: seg_modulus = FULL;
        2: seg_modulus = DB'(2);
        3: seg_modulus = DB'(6 * $urandom_range(1, 357913941));
        4: seg_modulus = DB'(720720);
        5: seg_modulus = DB'(998244353);
        default: seg_modulus = DB'($urandom_range(2, 32'h7FFF_FFFF));
      endcase
      write_modulus(seg_modulus);
      if (seg < 3) begin
        src_idle_pct = 36;
        snk_idle_pct = 63;
      end else if (seg < 5) begin
        src_idle_pct = 63;
        snk_idle_pct = 36;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      if (seg == 1) begin
        // Stall the receiver long enough that the result slot and the
        // in-flight operand both back up and operand.ready drops.
        queue_random(SEGMENT_ITEMS);
        sink_hold_left = 1500;
      end else if (seg == 4) begin
        // Pause the sender until every result is back, then resume.
        queue_random(SEGMENT_ITEMS / 2);
        drain_all();
        queue_random(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
      end else begin
        queue_random(SEGMENT_ITEMS);
      end
    end

    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_inverses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_inverses.size());
      error_count++;
    end

    $display("Checked %0d inverses across %0d modulus writes; %0d had gcd above one.",
             results_checked, modulus_writes, noncoprime_seen);
    $display("Idling mixes, a long receiver hold-off and a sender pause were exercised.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
